/* rtl/ulv_pkg.sv */
package ulv_pkg;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [1:0]  cont_left;
		logic [1:0]  seq_extra;
		logic [20:0] code_point;
		logic        failed;
	} ulv_dec_t;

	localparam int unsigned LEN_W = 6;

	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] ASCII_TOP  = 8'h80;

	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_VAL  = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_VAL  = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf8;
	localparam logic [7:0] LEAD4_VAL  = 8'hf0;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_VAL   = 8'h80;

	localparam logic [20:0] MIN_SEQ2   = 21'h000080;
	localparam logic [20:0] MIN_SEQ3   = 21'h000800;
	localparam logic [20:0] MIN_SEQ4   = 21'h010000;
	localparam logic [20:0] MAX_CP     = 21'h10ffff;
	localparam logic [20:0] SURR_FIRST = 21'h00d800;
	localparam logic [20:0] SURR_LAST  = 21'h00dfff;

	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

endpackage

/* rtl/utf8_label_validator_unit.sv */
// UTF-8 label validator. A label streams in one byte per transfer, with
// last_byte set on its final byte; one verdict transfer follows each label.
// label_ok is 1 when the label is strict UTF-8 (no overlong forms, no
// surrogates, nothing above U+10FFFF, no stray or missing continuation
// bytes), holds no byte below 0x20, and is at most MAX_LABEL_BYTES long.
// label_length is the byte count, saturating at MAX_LABEL_BYTES + 1 and
// reported in its low six bits. A transfer with empty_label set stands for a
// zero-length label: it is reported valid with length 0 and discards any
// label still in progress. The unit takes one byte every cycle while no
// verdict is held up by a full result register. The last byte passes through
// the input register stage, and its verdict is then held in the result register.
// The rate is set by the combinational decode step that closes the loop through
// the decoder state registers.
module utf8_label_validator_unit #(
	parameter int unsigned MAX_LABEL_BYTES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	input  logic                       empty_label,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       label_ok,
	output logic [ulv_pkg::LEN_W-1:0]  label_length
);
	import ulv_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_LABEL_BYTES + 2);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       empty_s1;

	// Per-label decoder state.
	logic [CNT_W-1:0] count_q;
	ulv_dec_t         dec_q;

	// Result register.
	logic             out_valid_q;
	logic             ok_q;
	logic [LEN_W-1:0] length_q;

	logic [CNT_W-1:0] next_count;
	ulv_dec_t         next_dec;
	logic             has_result;
	logic             step_ok;
	logic [LEN_W-1:0] step_length;
	logic             advance;

	ulv_label_step #(
		.MAX_LABEL_BYTES(MAX_LABEL_BYTES),
		.CNT_W(CNT_W)
	) u_step (
		.count(count_q),
		.dec(dec_q),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.empty_label(empty_s1),
		.next_count(next_count),
		.next_dec(next_dec),
		.has_result(has_result),
		.label_ok(step_ok),
		.label_length(step_length)
	);

	// The staged byte moves on unless it produces a verdict while the result
	// register is still full and not being drained this cycle.
	assign advance  = valid_s1 & (~has_result | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_label;
		end
	end

	// Decoder state updates only when the staged byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dec_q   <= '0;
		end else if (advance) begin
			count_q <= next_count;
			dec_q   <= next_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			ok_q     <= step_ok;
			length_q <= step_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign label_ok     = ok_q;
	assign label_length = length_q;

	// The byte count never runs past its saturation value.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LABEL_BYTES + 1))
		else $error("byte count beyond saturation");

	// Continuation bytes still expected never exceed the sequence length.
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.cont_left <= dec_q.seq_extra)
		else $error("continuation count exceeds sequence length");

	// With an empty result register the input stage never stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	// A failure stays recorded until the label ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.failed && advance && !last_s1 && !empty_s1 |=> dec_q.failed)
		else $error("failure flag lost within a label");

endmodule

/* rtl/ulv_label_step.sv */
module ulv_label_step #(
	parameter int unsigned MAX_LABEL_BYTES = 32,
	parameter int unsigned CNT_W = 6
) (
	input  logic [CNT_W-1:0]             count,
	input  ulv_pkg::ulv_dec_t            dec,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	input  logic                         empty_label,
	output logic [CNT_W-1:0]             next_count,
	output ulv_pkg::ulv_dec_t            next_dec,
	output logic                         has_result,
	output logic                         label_ok,
	output logic [ulv_pkg::LEN_W-1:0]    label_length
);
	import ulv_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LABEL_BYTES);
	localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_LABEL_BYTES + 1);

	logic [CNT_W-1:0] cnt_inc;
	ulv_dec_t         d;
	logic [1:0]       cont_dec;
	logic [20:0]      cp_shift;

	always_comb begin
		cnt_inc  = (count < CNT_SAT) ? count + 1'b1 : count;
		d        = dec;
		cont_dec = dec.cont_left - 2'd1;
		cp_shift = {dec.code_point[14:0], data_byte[5:0]};
		d.failed = dec.failed | (cnt_inc > CNT_LIMIT);

		if (dec.cont_left == 2'd0) begin
			// Expecting a lead byte or an ASCII byte.
			if (data_byte < CTRL_LIMIT) begin
				d.failed = 1'b1;
			end else if (data_byte < ASCII_TOP) begin
				d.failed = d.failed;
			end else if ((data_byte & LEAD2_MASK) == LEAD2_VAL) begin
				d.code_point = {16'd0, data_byte[4:0]};
				d.seq_extra  = SEQ_TWO;
				d.cont_left  = SEQ_TWO;
			end else if ((data_byte & LEAD3_MASK) == LEAD3_VAL) begin
				d.code_point = {17'd0, data_byte[3:0]};
				d.seq_extra  = SEQ_THREE;
				d.cont_left  = SEQ_THREE;
			end else if ((data_byte & LEAD4_MASK) == LEAD4_VAL) begin
				d.code_point = {18'd0, data_byte[2:0]};
				d.seq_extra  = SEQ_FOUR;
				d.cont_left  = SEQ_FOUR;
			end else begin
				d.failed = 1'b1;
			end
		end else if ((data_byte & CONT_MASK) != CONT_VAL) begin
			// A broken sequence fails the label and is dropped.
			d.failed    = 1'b1;
			d.cont_left = 2'd0;
		end else begin
			d.code_point = cp_shift;
			d.cont_left  = cont_dec;
			if (cont_dec == 2'd0) begin
				if (dec.seq_extra == SEQ_TWO && cp_shift < MIN_SEQ2) d.failed = 1'b1;
				if (dec.seq_extra == SEQ_THREE && cp_shift < MIN_SEQ3) d.failed = 1'b1;
				if (dec.seq_extra == SEQ_FOUR && cp_shift < MIN_SEQ4) d.failed = 1'b1;
				if (cp_shift > MAX_CP) d.failed = 1'b1;
				if (cp_shift >= SURR_FIRST && cp_shift <= SURR_LAST) d.failed = 1'b1;
			end
		end

		if (empty_label) begin
			has_result   = 1'b1;
			label_ok     = 1'b1;
			label_length = '0;
			next_count   = '0;
			next_dec     = '0;
		end else if (last_byte) begin
			has_result   = 1'b1;
			label_ok     = ~(d.failed | (d.cont_left != 2'd0));
			label_length = LEN_W'(cnt_inc);
			next_count   = '0;
			next_dec     = '0;
		end else begin
			has_result   = 1'b0;
			label_ok     = 1'b0;
			label_length = '0;
			next_count   = cnt_inc;
			next_dec     = d;
		end
	end

endmodule

/* verif/label_checker.sv */
module label_checker #(
	parameter int unsigned MAX_LABEL_BYTES = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	input  logic                      empty_label,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      label_ok,
	input  logic [ulv_pkg::LEN_W-1:0] label_length,
	output int                        mismatches,
	output int                        outstanding
);
	import ulv_pkg::*;

	typedef struct packed {
		logic             ok;
		logic [LEN_W-1:0] length;
	} verdict_t;

	verdict_t    pending_verdicts[$];
	verdict_t    want;
	ulv_dec_t    dec;
	int unsigned byte_count;

	function automatic void clear_label();
		dec = '0;
		byte_count = 0;
	endfunction

	// One step of the strict UTF-8 decoder on a byte of the current label.
	function automatic void decode_byte(input logic [7:0] b);
		logic [20:0] cp;
		if (dec.cont_left == 2'd0) begin
			if (b < CTRL_LIMIT) begin
				dec.failed = 1'b1;
			end else if (b < ASCII_TOP) begin
				// ASCII from 0x20 upwards needs nothing more.
			end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
				dec.code_point = {16'd0, b[4:0]};
				dec.seq_extra = SEQ_TWO;
				dec.cont_left = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
				dec.code_point = {17'd0, b[3:0]};
				dec.seq_extra = SEQ_THREE;
				dec.cont_left = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
				dec.code_point = {18'd0, b[2:0]};
				dec.seq_extra = SEQ_FOUR;
				dec.cont_left = 2'd3;
			end else begin
				dec.failed = 1'b1;
			end
			return;
		end
		if ((b & CONT_MASK) != CONT_VAL) begin
			dec.failed = 1'b1;
			dec.cont_left = 2'd0;
			return;
		end
		cp = {dec.code_point[14:0], b[5:0]};
		dec.code_point = cp;
		dec.cont_left = dec.cont_left - 2'd1;
		if (dec.cont_left == 2'd0) begin
			if (dec.seq_extra == SEQ_TWO && cp < MIN_SEQ2)
				dec.failed = 1'b1;
			if (dec.seq_extra == SEQ_THREE && cp < MIN_SEQ3)
				dec.failed = 1'b1;
			if (dec.seq_extra == SEQ_FOUR && cp < MIN_SEQ4)
				dec.failed = 1'b1;
			if (cp > MAX_CP)
				dec.failed = 1'b1;
			if (cp >= SURR_FIRST && cp <= SURR_LAST)
				dec.failed = 1'b1;
		end
	endfunction

	// Works out the verdict, if any, that an accepted input transfer causes.
	function automatic void predict_verdict(input logic [7:0] b, input logic last,
			input logic empty);
		verdict_t v;
		if (empty) begin
			clear_label();
			v.ok = 1'b1;
			v.length = '0;
			pending_verdicts.push_back(v);
			return;
		end
		if (byte_count < MAX_LABEL_BYTES + 1)
			byte_count++;
		if (byte_count > MAX_LABEL_BYTES)
			dec.failed = 1'b1;
		decode_byte(b);
		if (!last)
			return;
		if (dec.cont_left != 2'd0)
			dec.failed = 1'b1;
		v.ok = !dec.failed;
		v.length = byte_count[LEN_W-1:0];
		pending_verdicts.push_back(v);
		clear_label();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_label();
			pending_verdicts.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected verdict transfer: label_ok=%0b label_length=%0d",
						label_ok, label_length);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					if (label_ok !== want.ok) begin
						$error("label_ok: expected %0b, actual %0b", want.ok, label_ok);
						mismatches++;
					end
					if (label_length !== want.length) begin
						$error("label_length: expected %0d, actual %0d",
							want.length, label_length);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_verdict(data_byte, last_byte, empty_label);
		end
		outstanding = pending_verdicts.size();
	end

endmodule

/* verif/testbench.sv */
module testbench;
	import ulv_pkg::*;

	localparam int unsigned MAX_LABEL_BYTES = 32;
	// Longest run of cycles without any transfer before the run is declared hung.
	// The deliberate receiver hold-off below is far shorter than this.
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 500;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic                empty_label = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                label_ok;
	logic [LEN_W-1:0]    label_length;

	int mismatches;
	int outstanding;
	int sender_idle_pct = 21;
	int receiver_idle_pct = 72;
	int hold_request = 0;
	int hold_left = 0;
	int stall_count = 0;
	int random_items = 0;

	// Bytes of the label being assembled for the next send.
	logic [7:0] label_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	utf8_label_validator_unit #(
		.MAX_LABEL_BYTES(MAX_LABEL_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty_label(empty_label),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.label_ok(label_ok),
		.label_length(label_length)
	);

	label_checker #(
		.MAX_LABEL_BYTES(MAX_LABEL_BYTES)
	) verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty_label(empty_label),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.label_ok(label_ok),
		.label_length(label_length),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Verdict receiver. A hold-off request from the stimulus is turned into a long
	// stretch of ready low, counted here; otherwise ready drops at random with the
	// current idle rate. Ready changes only on the falling edge.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = HOLD_CYCLES;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Hang detection: any transfer on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offers one byte transfer. The task is entered and left on a falling edge.
	// Before offering, valid may idle for a random number of cycles; once high it
	// stays high with a steady payload until the rising edge that accepts it.
	task automatic offer(input logic [7:0] b, input logic last, input logic empty);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		empty_label <= empty;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Sends label_q with the last mark on its final byte. With noise on, an empty
	// label may cut in now and then, which discards the label in progress.
	task automatic send_label(input bit noise);
		for (int i = 0; i < label_q.size(); i++) begin
			if (noise && i > 0 && $urandom_range(99) < 2) begin
				offer(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
				random_items++;
			end
			offer(label_q[i], i == label_q.size() - 1, 1'b0);
			if (noise)
				random_items++;
		end
	endtask

	// Appends the UTF-8 form of a code point with the given number of continuation
	// bytes. Out-of-range values and wrong lengths are deliberate: they make
	// overlong forms, surrogates, leads of F5 to F7 and so on. With cut set, the
	// final continuation byte is left out.
	function automatic void encode_char(input int unsigned cp, input int extra,
			input bit cut);
		case (extra)
			0: label_q.push_back(8'(cp));
			1: label_q.push_back(LEAD2_VAL | 8'((cp >> 6) & 'h1f));
			2: label_q.push_back(LEAD3_VAL | 8'((cp >> 12) & 'h0f));
			default: label_q.push_back(LEAD4_VAL | 8'((cp >> 18) & 'h07));
		endcase
		for (int k = extra - 1; k >= (cut ? 1 : 0); k--)
			label_q.push_back(CONT_VAL | 8'((cp >> (6 * k)) & 'h3f));
	endfunction

	// Builds and sends one random label. Most characters are well formed, so that
	// many labels pass and the decoder runs deep into multibyte sequences; the
	// rest are garbled encodings, code points on the edges of the legal ranges,
	// raw bytes and cut-off sequences. A few labels run past the length limit.
	task automatic random_label();
		int kind;
		int unsigned cp;
		int unsigned corner_cp[12] = '{'h7f, 'h80, 'h7ff, 'h800, 'hd7ff, 'hd800,
			'hdfff, 'he000, 'hffff, 'h10000, 'h10ffff, 'h110000};
		label_q.delete();
		kind = $urandom_range(99);
		if (kind < 4) begin
			offer(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
			random_items++;
			return;
		end
		if (kind < 9) begin
			repeat ($urandom_range(29, 36))
				label_q.push_back(8'($urandom_range(32, 126)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				kind = $urandom_range(99);
				if (kind < 38) begin
					encode_char($urandom_range(32, 127), 0, 1'b0);
				end else if (kind < 53) begin
					encode_char($urandom_range('h80, 'h7ff), 1, 1'b0);
				end else if (kind < 65) begin
					cp = $urandom_range('h800, 'hffff);
					if (cp >= 'hd800 && cp <= 'hdfff)
						cp += 'h800;
					encode_char(cp, 2, 1'b0);
				end else if (kind < 75) begin
					encode_char($urandom_range('h10000, 'h10ffff), 3, 1'b0);
				end else if (kind < 81) begin
					encode_char($urandom_range(0, 'h1fffff), $urandom_range(1, 3), 1'b0);
				end else if (kind < 89) begin
					encode_char(corner_cp[$urandom_range(11)], $urandom_range(1, 3), 1'b0);
				end else if (kind < 95) begin
					label_q.push_back(8'($urandom_range(255)));
				end else begin
					encode_char($urandom_range(0, 'h1fffff), $urandom_range(1, 3), 1'b1);
				end
			end
		end
		send_label(1'b1);
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed labels. An empty label on its own, then one that discards a
		// label in progress, with the last mark low and junk in the byte field.
		offer(8'h00, 1'b1, 1'b1);
		offer(8'h41, 1'b0, 1'b0);
		offer(8'he2, 1'b0, 1'b0);
		offer(8'hff, 1'b0, 1'b1);
		// NUL, then the control-byte boundary and the top of ASCII.
		label_q = '{8'h00};
		send_label(1'b0);
		label_q = '{8'h20, 8'h7f};
		send_label(1'b0);
		// Overlong two-byte form and an encoded surrogate.
		label_q = '{8'hc0, 8'h80};
		send_label(1'b0);
		label_q = '{8'hed, 8'ha0, 8'h80};
		send_label(1'b0);
		// Just above U+10FFFF, and the lowest legal four-byte character.
		label_q = '{8'hf4, 8'h90, 8'h80, 8'h80};
		send_label(1'b0);
		label_q = '{8'hf0, 8'h90, 8'h80, 8'h80};
		send_label(1'b0);
		// Invalid lead, stray continuation, bad continuation, cut-off sequence.
		label_q = '{8'hff};
		send_label(1'b0);
		label_q = '{8'h80};
		send_label(1'b0);
		label_q = '{8'hc2, 8'h41};
		send_label(1'b0);
		label_q = '{8'he2, 8'h82};
		send_label(1'b0);

		// Random part, first with a mostly stalled receiver.
		while (random_items < RANDOM_ITEMS / 3)
			random_label();

		// Now a mostly idle sender and an eager receiver.
		sender_idle_pct = 72;
		receiver_idle_pct = 21;
		while (random_items < 2 * RANDOM_ITEMS / 3)
			random_label();

		// No idling on either side. The receiver first holds off for a long
		// stretch while one-byte labels keep coming, so the verdict path backs
		// up and the input has to stall.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_request = 1;
		repeat (40) begin
			offer(8'($urandom_range(32, 126)), 1'b1, 1'b0);
			random_items++;
		end
		while (random_items < RANDOM_ITEMS)
			random_label();
		in_valid <= 1'b0;

		// Drain: the watchdog ends the run if a verdict never shows up.
		while (outstanding != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
